// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define PCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/pcb_pkg.sv =====
package pcb_pkg;

  // Field widths
  localparam int CoordW    = 16;
  localparam int HalfW     = 15;
  localparam int CountW    = 17;
  localparam int DistW     = 31;
  localparam int CfgIdxW   = 3;
  localparam int CfgWdataW = 16;

  // Count saturates at the smaller of the point limit and the field maximum
  localparam int MaxPoints     = 65536;
  localparam int CountFieldMax = (2 ** CountW) - 1;
  localparam logic [CountW-1:0] CountLimit =
      CountW'((MaxPoints < CountFieldMax) ? MaxPoints : CountFieldMax);

  // Bounds seen for an empty cloud
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [DistW-1:0]         DistAllOnes = {DistW{1'b1}};

  // Register reset values, millimetres
  localparam logic signed [CoordW-1:0] BoxXLowRst     = 16'sd150;
  localparam logic signed [CoordW-1:0] BoxXHighRst    = 16'sd4000;
  localparam logic [HalfW-1:0]         BoxHalfWidthRst = 15'd1200;
  localparam logic signed [CoordW-1:0] BoxZLowRst     = -16'sd400;
  localparam logic signed [CoordW-1:0] BoxZHighRst    = 16'sd600;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBoxXLow      = 3'd0,
    CfgBoxXHigh     = 3'd1,
    CfgBoxHalfWidth = 3'd2,
    CfgBoxZLow      = 3'd3,
    CfgBoxZHigh     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x_mm;
    logic signed [CoordW-1:0] y_mm;
    logic signed [CoordW-1:0] z_mm;
    logic                     not_finite;
    logic                     end_of_cloud;
  } point_t;

  typedef struct packed {
    logic [CountW-1:0]        valid_count;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_z;
    logic                     found;
    logic [DistW-1:0]         nearest_dist_sq;
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
    logic signed [CoordW-1:0] near_z;
  } result_t;

endpackage

// ===== rtl/pcb_if.sv =====
// Point channel: one lidar point per item
interface pcb_point_if;
  logic            valid;
  logic            ready;
  pcb_pkg::point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one cloud summary per item
interface pcb_result_if;
  logic             valid;
  logic             ready;
  pcb_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/point_cloud_bbox_nearest_obstacle.sv =====
// Point cloud bounding box and nearest forward obstacle. Takes one point per
// cycle on point_i; a point flagged not finite or sitting at the origin is
// skipped, every other point is counted and widens the x/y/z bounds, and a
// point inside the forward box set by the five box registers competes for the
// nearest slot by x*x + y*y (the earliest of equal distances wins). The point
// marked end_of_cloud closes the cloud, even when skipped itself: one summary
// item is registered for result_o as that point leaves the input register, and
// the running state is cleared for the next cloud. Throughput is one point per
// cycle, set by the single input register feeding the compare, square and
// accumulate logic; the input stalls only when a closing point meets a summary
// that result_o has not yet taken. Write the box registers only while idle.
module point_cloud_bbox_nearest_obstacle (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcb_pkg::CfgWdataW-1:0] cfg_wdata_i,
  pcb_point_if.sink                     point_i,
  pcb_result_if.source                  result_o
);

  localparam int CoordW = pcb_pkg::CoordW;
  localparam int CountW = pcb_pkg::CountW;
  localparam int DistW  = pcb_pkg::DistW;
  localparam int HalfW  = pcb_pkg::HalfW;

  // Box registers
  logic signed [CoordW-1:0] box_x_low_q, box_x_high_q, box_z_low_q, box_z_high_q;
  logic [HalfW-1:0]         box_half_width_q;

  // Input stage
  logic            s1_valid_q;
  pcb_pkg::point_t s1_pt_q;
  logic            s1_adv;

  // Running cloud state
  logic [CountW-1:0]        cnt_q, cnt_d;
  logic signed [CoordW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
  logic signed [CoordW-1:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d, lo_z_d, hi_z_d;
  logic                     have_q, have_d;
  logic [DistW-1:0]         best_q, best_d;
  logic signed [CoordW-1:0] bx_q, by_q, bz_q, bx_d, by_d, bz_d;

  // Result register
  logic             res_valid_q;
  pcb_pkg::result_t res_q;

  // Point datapath
  logic signed [CoordW-1:0] px, py, pz;
  logic                     keep, in_box, take;
  logic [CoordW-1:0]        ax, ay;
  logic [2*CoordW-1:0]      sq_x, sq_y;
  logic [2*CoordW:0]        dist_sum;
  logic [DistW-1:0]         dist_sat;

  // Write box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_low_q      <= pcb_pkg::BoxXLowRst;
      box_x_high_q     <= pcb_pkg::BoxXHighRst;
      box_half_width_q <= pcb_pkg::BoxHalfWidthRst;
      box_z_low_q      <= pcb_pkg::BoxZLowRst;
      box_z_high_q     <= pcb_pkg::BoxZHighRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcb_pkg::CfgBoxXLow:      box_x_low_q      <= cfg_wdata_i;
        pcb_pkg::CfgBoxXHigh:     box_x_high_q     <= cfg_wdata_i;
        pcb_pkg::CfgBoxHalfWidth: box_half_width_q <= cfg_wdata_i[HalfW-1:0];
        pcb_pkg::CfgBoxZLow:      box_z_low_q      <= cfg_wdata_i;
        pcb_pkg::CfgBoxZHigh:     box_z_high_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the registered point unless it closes a cloud onto a held result
  assign s1_adv = s1_valid_q &
                  (~s1_pt_q.end_of_cloud | ~res_valid_q | result_o.ready);
  assign point_i.ready = ~s1_valid_q | ~s1_pt_q.end_of_cloud | ~res_valid_q |
                         result_o.ready;

  // Hold the point in the input register while it is worked on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (point_i.ready) begin
      s1_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_i.valid && point_i.ready) begin
      s1_pt_q <= point_i.data;
    end
  end

  // Filter, box test and planar squared distance
  assign px   = s1_pt_q.x_mm;
  assign py   = s1_pt_q.y_mm;
  assign pz   = s1_pt_q.z_mm;
  assign keep = ~s1_pt_q.not_finite & ~((px == '0) & (py == '0) & (pz == '0));
  assign ax   = px[CoordW-1] ? (~px + 1'b1) : px;
  assign ay   = py[CoordW-1] ? (~py + 1'b1) : py;

  assign in_box = (px > box_x_low_q) && (px < box_x_high_q) &&
                  (ay < {1'b0, box_half_width_q}) &&
                  (pz > box_z_low_q) && (pz < box_z_high_q);

  assign sq_x     = ax * ax;
  assign sq_y     = ay * ay;
  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign dist_sat = (|dist_sum[2*CoordW:DistW]) ? pcb_pkg::DistAllOnes
                                                 : dist_sum[DistW-1:0];

  assign take = keep && in_box && (!have_q || (dist_sat < best_q));

  // Fold the point into the running state
  always_comb begin
    cnt_d  = (keep && (cnt_q < pcb_pkg::CountLimit)) ? cnt_q + 1'b1 : cnt_q;
    lo_x_d = (keep && (px < lo_x_q)) ? px : lo_x_q;
    hi_x_d = (keep && (px > hi_x_q)) ? px : hi_x_q;
    lo_y_d = (keep && (py < lo_y_q)) ? py : lo_y_q;
    hi_y_d = (keep && (py > hi_y_q)) ? py : hi_y_q;
    lo_z_d = (keep && (pz < lo_z_q)) ? pz : lo_z_q;
    hi_z_d = (keep && (pz > hi_z_q)) ? pz : hi_z_q;
    have_d = have_q | take;
    best_d = take ? dist_sat : best_q;
    bx_d   = take ? px : bx_q;
    by_d   = take ? py : by_q;
    bz_d   = take ? pz : bz_q;
  end

  // Update state; clear it once a cloud closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lo_x_q <= pcb_pkg::CoordMax;
      hi_x_q <= pcb_pkg::CoordMin;
      lo_y_q <= pcb_pkg::CoordMax;
      hi_y_q <= pcb_pkg::CoordMin;
      lo_z_q <= pcb_pkg::CoordMax;
      hi_z_q <= pcb_pkg::CoordMin;
      have_q <= 1'b0;
      best_q <= pcb_pkg::DistAllOnes;
      bx_q   <= '0;
      by_q   <= '0;
      bz_q   <= '0;
    end else if (s1_adv) begin
      if (s1_pt_q.end_of_cloud) begin
        cnt_q  <= '0;
        lo_x_q <= pcb_pkg::CoordMax;
        hi_x_q <= pcb_pkg::CoordMin;
        lo_y_q <= pcb_pkg::CoordMax;
        hi_y_q <= pcb_pkg::CoordMin;
        lo_z_q <= pcb_pkg::CoordMax;
        hi_z_q <= pcb_pkg::CoordMin;
        have_q <= 1'b0;
        best_q <= pcb_pkg::DistAllOnes;
        bx_q   <= '0;
        by_q   <= '0;
        bz_q   <= '0;
      end else begin
        cnt_q  <= cnt_d;
        lo_x_q <= lo_x_d;
        hi_x_q <= hi_x_d;
        lo_y_q <= lo_y_d;
        hi_y_q <= hi_y_d;
        lo_z_q <= lo_z_d;
        hi_z_q <= hi_z_d;
        have_q <= have_d;
        best_q <= best_d;
        bx_q   <= bx_d;
        by_q   <= by_d;
        bz_q   <= bz_d;
      end
    end
  end

  // Load the summary item; drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_pt_q.end_of_cloud) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pt_q.end_of_cloud) begin
      res_q.valid_count     <= cnt_d;
      res_q.min_x           <= lo_x_d;
      res_q.max_x           <= hi_x_d;
      res_q.min_y           <= lo_y_d;
      res_q.max_y           <= hi_y_d;
      res_q.min_z           <= lo_z_d;
      res_q.max_z           <= hi_z_d;
      res_q.found           <= have_d;
      res_q.nearest_dist_sq <= best_d;
      res_q.near_x          <= bx_d;
      res_q.near_y          <= by_d;
      res_q.near_z          <= bz_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

// ===== rtl/pcb_checker.sv =====
`include "assert_macros.svh"

module pcb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input pcb_pkg::result_t res_data_i
);

  // A stalled summary item keeps its place and contents
  `PCB_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i), "result item changed while stalled")

  // With no summary waiting the block must take points
  `PCB_ASSERT(a_ready_when_empty, !res_valid_i |-> in_ready_i, "input stalled with empty output")

  // No box point leaves the nearest fields at their cleared values
  `PCB_ASSERT(a_not_found_fields, res_valid_i && !res_data_i.found |-> res_data_i.nearest_dist_sq == pcb_pkg::DistAllOnes && res_data_i.near_x == '0 && res_data_i.near_y == '0 && res_data_i.near_z == '0, "nearest fields set without a box point")

  // An empty cloud reports cleared x and z bounds and nothing found
  `PCB_ASSERT(a_empty_cloud, res_valid_i && res_data_i.valid_count == '0 |-> !res_data_i.found && res_data_i.min_x == pcb_pkg::CoordMax && res_data_i.max_x == pcb_pkg::CoordMin && res_data_i.min_z == pcb_pkg::CoordMax && res_data_i.max_z == pcb_pkg::CoordMin, "empty cloud reports data")

endmodule

bind point_cloud_bbox_nearest_obstacle pcb_checker u_pcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (point_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_data_i  (result_o.data)
);
